FILE: sv/whtr_pkg.sv
// Shared types and constants for the window hit-test and raise block.
// No dependencies; imported by every module of the block.
package whtr_pkg;

    localparam int X_W    = 12;
    localparam int Y_W    = 11;
    localparam int NUM_W  = 5;
    localparam int KIND_W = 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_CLICK = 1'b1;

    localparam logic [KIND_W-1:0] KIND_HIT     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd2;

    // One stacked window: its rectangle and its load-order number.
    typedef struct packed {
        logic [X_W-1:0]   left;
        logic [Y_W-1:0]   bottom;
        logic [X_W-1:0]   right;
        logic [Y_W-1:0]   top_edge;
        logic [NUM_W-1:0] number;
    } whtr_entry_t;

endpackage

FILE: sv/window_hit_test_raise_core.sv
// Top level of the window stack: sequencer, window memory and result register.
// Depends on whtr_pkg and instantiates whtr_hit_unit.
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+------------------------------------------------
//  input   | in_valid / in_ready   | op, left, bottom, right, top_edge, point_x, point_y
//  output  | out_valid / out_ready | kind, window_number
//
// A load request that fits is written into memory and produces no result; a
// dropped load goes through the hand-over state to the result register. A click
// scans the stacked windows from the top down through the single memory read
// port and the shared compare unit; on a hit each window above the hit one is
// shifted down, the hit window is placed on top, and the result is handed over.
// Reset clears the sequencer, the window count and the result register; the
// memory holds no reset value and is only read below the count. A result
// waiting in the output register does not block the next request; only a
// finished result stalls, in the hand-over state, while the output register is
// still full.
module window_hit_test_raise_core #(
    parameter int MAX_WINDOWS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           op,
    input  logic [whtr_pkg::X_W-1:0]       left,
    input  logic [whtr_pkg::Y_W-1:0]       bottom,
    input  logic [whtr_pkg::X_W-1:0]       right,
    input  logic [whtr_pkg::Y_W-1:0]       top_edge,
    input  logic [whtr_pkg::X_W-1:0]       point_x,
    input  logic [whtr_pkg::Y_W-1:0]       point_y,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [whtr_pkg::KIND_W-1:0]    kind,
    output logic [whtr_pkg::NUM_W-1:0]     window_number
);
    import whtr_pkg::*;

    // Count width holds MAX_WINDOWS itself; the address width covers the depth.
    localparam int CW = $clog2(MAX_WINDOWS + 1);
    localparam int AW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE,
        ST_PLACE,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [X_W-1:0]      px_reg, px_next;
    logic [Y_W-1:0]      py_reg, py_next;
    whtr_entry_t         hit_reg, hit_next;
    logic [KIND_W-1:0]   res_kind_reg, res_kind_next;
    logic [NUM_W-1:0]    res_num_reg, res_num_next;
    logic                out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [NUM_W-1:0]    number_reg, number_next;

    // Window memory: one write port and one registered read port.
    whtr_entry_t         mem [MAX_WINDOWS];
    whtr_entry_t         rd_data_reg;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    whtr_entry_t         wr_data;

    logic                hit;
    logic                full;
    logic [AW-1:0]       last;
    logic [31:0]         count_ext;
    whtr_entry_t         new_entry;

    whtr_hit_unit u_hit (
        .entry (rd_data_reg),
        .px    (px_reg),
        .py    (py_reg),
        .hit   (hit)
    );

    assign full      = (count_reg == CW'(MAX_WINDOWS));
    assign last      = AW'(count_reg - CW'(1));
    // Window numbers are the new count, kept to the five bits of the result.
    assign count_ext = 32'(count_reg) + 32'd1;

    always_comb
    begin
        new_entry.left     = left;
        new_entry.bottom   = bottom;
        new_entry.right    = right;
        new_entry.top_edge = top_edge;
        new_entry.number   = count_ext[NUM_W-1:0];
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign window_number = number_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        hit_next       = hit_reg;
        res_kind_next  = res_kind_reg;
        res_num_next   = res_num_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        number_next    = number_reg;
        rd_addr        = pos_reg;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = rd_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == OP_LOAD)
                    begin
                        if (full)
                        begin
                            res_kind_next = KIND_DROPPED;
                            res_num_next  = '0;
                            state_next    = ST_DONE;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[AW-1:0];
                            wr_data    = new_entry;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        px_next = point_x;
                        py_next = point_y;
                        if (count_reg == '0)
                        begin
                            res_kind_next = KIND_IGNORED;
                            res_num_next  = '0;
                            state_next    = ST_DONE;
                        end
                        else
                        begin
                            // Start the walk at the top of the stack.
                            rd_addr    = last;
                            pos_next   = last;
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if (hit)
                begin
                    hit_next      = rd_data_reg;
                    res_kind_next = KIND_HIT;
                    res_num_next  = rd_data_reg.number;
                    if (pos_reg == last)
                    begin
                        // Already on top, so the order does not change.
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rd_addr    = pos_reg + AW'(1);
                        pos_next   = pos_reg + AW'(1);
                        state_next = ST_MOVE;
                    end
                end
                else if (pos_reg == '0)
                begin
                    res_kind_next = KIND_IGNORED;
                    res_num_next  = '0;
                    state_next    = ST_DONE;
                end
                else
                begin
                    rd_addr  = pos_reg - AW'(1);
                    pos_next = pos_reg - AW'(1);
                end
            end

            ST_MOVE:
            begin
                // The entry just read slides down one place.
                wr_en   = 1'b1;
                wr_addr = pos_reg - AW'(1);
                wr_data = rd_data_reg;
                if (pos_reg == last)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    rd_addr  = pos_reg + AW'(1);
                    pos_next = pos_reg + AW'(1);
                end
            end

            ST_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = last;
                wr_data    = hit_reg;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = res_kind_reg;
                    number_next    = res_num_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pos_reg       <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            hit_reg       <= '0;
            res_kind_reg  <= KIND_IGNORED;
            res_num_reg   <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_IGNORED;
            number_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            hit_reg       <= hit_next;
            res_kind_reg  <= res_kind_next;
            res_num_reg   <= res_num_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            number_reg    <= number_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    // The stack never holds more windows than it has room for.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_WINDOWS))
        else $error("window count above capacity");

    // A load that fits grows the stack by exactly one window.
    a_load_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (op == OP_LOAD) && !full)
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("load did not add a window");

    // A click only reorders the stack and never changes its size.
    a_click_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (op == OP_CLICK)) |=> $stable(count_reg))
        else $error("click changed the window count");

    // A hit names a real window, as long as numbers fit the result field.
    a_hit_number: assert property (@(posedge clk) disable iff (!rst_n)
        ((MAX_WINDOWS < 32) && (state_reg == ST_DONE) && (res_kind_reg == KIND_HIT))
        |-> (res_num_reg != '0))
        else $error("hit reported without a window number");

endmodule

FILE: sv/whtr_hit_unit.sv
// Shared containment compare: tests one stored window against the click point.
// Depends on whtr_pkg for the entry type and coordinate widths.
module whtr_hit_unit (
    input  whtr_pkg::whtr_entry_t  entry,
    input  logic [whtr_pkg::X_W-1:0] px,
    input  logic [whtr_pkg::Y_W-1:0] py,
    output logic                     hit
);
    import whtr_pkg::*;

    // Every edge is inclusive; an inverted rectangle can never match.
    assign hit = (px >= entry.left) && (px <= entry.right) &&
                 (py >= entry.bottom) && (py <= entry.top_edge);

endmodule

FILE: dv/tb.sv
// Self-checking testbench for window_hit_test_raise_core: a directed table of load and
// click requests, then random requests, checked against a predictor or a row's own result.
// Depends on whtr_pkg and the window_hit_test_raise_core RTL.
module tb;
    import whtr_pkg::*;

    // The stack depth that the block is built with, and the field ranges of a screen.
    localparam int STACK_DEPTH = 16;
    localparam int X_MAX = 2559;
    localparam int Y_MAX = 1439;

    // Number of random requests after the directed table.
    localparam int RANDOM_REQUESTS = 2000;

    // The drain after the last result allows for the slowest click over a full stack
    // with margin, so a stray late result is still caught.
    localparam int DRAIN_CYCLES = 2 * STACK_DEPTH + 30;

    // The receiver's long hold-off, and the number of cycles without any transfer on
    // either channel after which the run is declared hung. The limit covers the hold
    // plus the slowest click plus the longest random stalls several times over.
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;

    localparam int N_DIRECTED = 25;

    typedef struct packed {
        logic [X_W-1:0] left;
        logic [Y_W-1:0] bottom;
        logic [X_W-1:0] right;
        logic [Y_W-1:0] top_edge;
    } rect_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NUM_W-1:0]  number;
    } click_result_t;

    // One request as the sender offers it. When typed is set, the row carries its own
    // expected result and the predictor's answer is not used for it.
    typedef struct packed {
        logic          op;
        rect_t         rect;
        logic [X_W-1:0] px;
        logic [Y_W-1:0] py;
        logic          typed;
        click_result_t result;
    } request_row_t;

    // Directed requests. Loads are numbered in order: #1 is the full screen, #2 and #3
    // are inverted and can never be hit, #4 is a small window, #5 to #16 fill the
    // stack with overlapping windows, two of them single pixels at the corners.
    localparam request_row_t DIRECTED [N_DIRECTED] = '{
        // Click on an empty stack is ignored.
        '{OP_CLICK, '{1234, 567, 89, 1000},     5,    5,    1'b1, '{KIND_IGNORED, 0}},
        '{OP_LOAD,  '{0, 0, 2559, 1439},        2559, 1439, 1'b0, '0},
        // Both extreme corners hit the full-screen window, edges inclusive.
        '{OP_CLICK, '{2559, 1439, 2559, 1439},  0,    0,    1'b1, '{KIND_HIT, 1}},
        '{OP_CLICK, '{0, 0, 0, 0},              2559, 1439, 1'b1, '{KIND_HIT, 1}},
        '{OP_LOAD,  '{2000, 0, 100, 1439},      1024, 512,  1'b0, '0},
        '{OP_LOAD,  '{0, 1400, 2559, 10},       0,    0,    1'b0, '0},
        '{OP_LOAD,  '{100, 100, 200, 200},      77,   99,   1'b0, '0},
        // Corner of the small top window, then a point only the bottom window holds,
        // which raises it past the small window and the two inverted windows.
        '{OP_CLICK, '{0, 0, 0, 0},              100,  200,  1'b0, '0},
        '{OP_CLICK, '{300, 20, 400, 30},        1000, 700,  1'b0, '0},
        '{OP_LOAD,  '{200, 200, 800, 600},      0,    0,    1'b0, '0},
        '{OP_LOAD,  '{500, 400, 1200, 900},     1,    1,    1'b0, '0},
        '{OP_LOAD,  '{1000, 800, 1800, 1300},   2,    2,    1'b0, '0},
        '{OP_LOAD,  '{1500, 100, 2559, 700},    3,    3,    1'b0, '0},
        '{OP_LOAD,  '{0, 1000, 600, 1439},      4,    4,    1'b0, '0},
        '{OP_LOAD,  '{300, 300, 400, 400},      5,    5,    1'b0, '0},
        '{OP_LOAD,  '{2048, 1024, 2559, 1439},  6,    6,    1'b0, '0},
        '{OP_LOAD,  '{700, 50, 900, 1100},      7,    7,    1'b0, '0},
        '{OP_LOAD,  '{1536, 512, 2047, 1023},   8,    8,    1'b0, '0},
        '{OP_LOAD,  '{256, 768, 1279, 1279},    9,    9,    1'b0, '0},
        '{OP_LOAD,  '{2559, 1439, 2559, 1439},  10,   10,   1'b0, '0},
        '{OP_LOAD,  '{0, 0, 0, 0},              11,   11,   1'b0, '0},
        // The stack is full now, so this load is dropped.
        '{OP_LOAD,  '{10, 10, 20, 20},          12,   12,   1'b1, '{KIND_DROPPED, 0}},
        '{OP_CLICK, '{0, 0, 0, 0},              2559, 1439, 1'b0, '0},
        '{OP_CLICK, '{0, 0, 0, 0},              350,  350,  1'b0, '0},
        '{OP_CLICK, '{0, 0, 0, 0},              120,  120,  1'b0, '0}
    };

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                op;
    logic [X_W-1:0]      left;
    logic [Y_W-1:0]      bottom;
    logic [X_W-1:0]      right;
    logic [Y_W-1:0]      top_edge;
    logic [X_W-1:0]      point_x;
    logic [Y_W-1:0]      point_y;
    logic                out_valid;
    logic                out_ready;
    logic [KIND_W-1:0]   kind;
    logic [NUM_W-1:0]    window_number;

    // Predicted window stack, bottom first, and the results still owed by the block.
    rect_t               win_rect [STACK_DEPTH];
    logic [NUM_W-1:0]    win_number [STACK_DEPTH];
    int                  win_count;
    click_result_t       expected_results [$];
    click_result_t       oldest_expected;

    int                  error_count;
    int                  stall_cycles;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    bit                  long_hold_req;

    window_hit_test_raise_core #(
        .MAX_WINDOWS (STACK_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .left          (left),
        .bottom        (bottom),
        .right         (right),
        .top_edge      (top_edge),
        .point_x       (point_x),
        .point_y       (point_y),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .window_number (window_number)
    );

    initial clk = 1'b0;

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Applies one request to the predicted stack. A load pushes the window on top
    // with the next load-order number, or is dropped when the stack is full. A click
    // scans from the top down; the first window that holds the point, edges
    // inclusive, is reported and moved to the top while the rest keep their order.
    // Returns whether the request produces a result.
    function automatic bit stack_apply(input request_row_t req, output click_result_t res);
        int               pos;
        int               m;
        rect_t            hit_rect;
        logic [NUM_W-1:0] hit_num;
        res = '0;
        if (req.op == OP_LOAD)
        begin
            if (win_count >= STACK_DEPTH)
            begin
                res.kind = KIND_DROPPED;
                return 1'b1;
            end
            win_rect[win_count] = req.rect;
            win_number[win_count] = NUM_W'(win_count + 1);
            win_count++;
            return 1'b0;
        end
        for (pos = win_count - 1; pos >= 0; pos--)
        begin
            if (req.px >= win_rect[pos].left && req.px <= win_rect[pos].right &&
                req.py >= win_rect[pos].bottom && req.py <= win_rect[pos].top_edge)
            begin
                hit_rect = win_rect[pos];
                hit_num = win_number[pos];
                for (m = pos; m < win_count - 1; m++)
                begin
                    win_rect[m] = win_rect[m + 1];
                    win_number[m] = win_number[m + 1];
                end
                win_rect[win_count - 1] = hit_rect;
                win_number[win_count - 1] = hit_num;
                res.kind = KIND_HIT;
                res.number = hit_num;
                return 1'b1;
            end
        end
        res.kind = KIND_IGNORED;
        return 1'b1;
    endfunction

    // Random request. Once the table has run the stack stays full, so loads are
    // always dropped; most clicks aim inside a stacked window, often on its edges,
    // so the scan stops at every depth and raises windows from every position.
    // The fields a request does not use carry random values throughout.
    function automatic request_row_t random_request();
        request_row_t req;
        rect_t        target;
        int           choice;
        int           edge_pick;
        req.typed = 1'b0;
        req.result = '0;
        req.rect.left = X_W'($urandom_range(X_MAX));
        req.rect.bottom = Y_W'($urandom_range(Y_MAX));
        req.rect.right = X_W'($urandom_range(X_MAX));
        req.rect.top_edge = Y_W'($urandom_range(Y_MAX));
        req.px = X_W'($urandom_range(X_MAX));
        req.py = Y_W'($urandom_range(Y_MAX));
        choice = $urandom_range(99);
        if (choice < 15)
        begin
            req.op = OP_LOAD;
        end
        else
        begin
            req.op = OP_CLICK;
            if (choice < 85 && win_count > 0)
            begin
                target = win_rect[$urandom_range(win_count - 1)];
                if (target.left <= target.right && target.bottom <= target.top_edge)
                begin
                    edge_pick = $urandom_range(3);
                    req.px = (edge_pick == 0) ? target.left :
                             (edge_pick == 1) ? target.right :
                             X_W'($urandom_range(target.right, target.left));
                    edge_pick = $urandom_range(3);
                    req.py = (edge_pick == 0) ? target.bottom :
                             (edge_pick == 1) ? target.top_edge :
                             Y_W'($urandom_range(target.top_edge, target.bottom));
                end
            end
        end
        return req;
    endfunction

    // Offers one request at a falling edge, after a random gap, and holds it until
    // the block accepts it. On acceptance the predictor runs and the expected result,
    // if any, is queued. Returns at the falling edge after the accepting edge.
    task automatic send_request(input request_row_t req);
        click_result_t predicted;
        bit            has_result;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= req.op;
        left <= req.rect.left;
        bottom <= req.rect.bottom;
        right <= req.rect.right;
        top_edge <= req.rect.top_edge;
        point_x <= req.px;
        point_y <= req.py;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        has_result = stack_apply(req, predicted);
        if (req.typed)
        begin
            expected_results = {expected_results, req.result};
        end
        else if (has_result)
        begin
            expected_results = {expected_results, predicted};
        end
        @(negedge clk);
    endtask

    // Receiver: drives out_ready at each falling edge. When a long hold is requested
    // it keeps out_ready low for the long hold-off, so that the result register
    // and the hand-over state fill and the block stops taking requests.
    initial
    begin
        int held;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                for (held = 1; held < LONG_HOLD_CYCLES; held++)
                begin
                    @(negedge clk);
                end
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Result checker: every transferred result is compared with the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("result kind %0d number %0d with none expected",
                                          kind, window_number));
            end
            else
            begin
                oldest_expected = expected_results.pop_front();
                if (kind !== oldest_expected.kind)
                begin
                    report_mismatch($sformatf("kind %0d, expected %0d",
                                              kind, oldest_expected.kind));
                end
                if (window_number !== oldest_expected.number)
                begin
                    report_mismatch($sformatf("window number %0d, expected %0d",
                                              window_number, oldest_expected.number));
                end
            end
        end
    end

    // Watchdog: ends the run when neither channel has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Main sequence: reset, the directed table, then random requests in three idling
    // phases. The long receiver hold opens the last phase, where the sender never
    // idles, so the block is sure to back up into its input.
    initial
    begin
        int idx;
        in_valid = 1'b0;
        op = OP_LOAD;
        left = '0;
        bottom = '0;
        right = '0;
        top_edge = '0;
        point_x = '0;
        point_y = '0;
        rst_n = 1'b0;
        win_count = 0;
        error_count = 0;
        stall_cycles = 0;
        long_hold_req = 1'b0;
        send_idle_pct = 12;
        recv_idle_pct = 53;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (idx = 0; idx < N_DIRECTED; idx++)
        begin
            send_request(DIRECTED[idx]);
        end

        for (idx = 0; idx < RANDOM_REQUESTS; idx++)
        begin
            if (idx == RANDOM_REQUESTS / 3)
            begin
                send_idle_pct = 53;
                recv_idle_pct = 12;
            end
            if (idx == 2 * RANDOM_REQUESTS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                long_hold_req = 1'b1;
            end
            send_request(random_request());
        end
        in_valid <= 1'b0;

        // Wait for every owed result, then give a late extra result time to show up.
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_results.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/whtr_pkg.sv
sv/whtr_hit_unit.sv
sv/window_hit_test_raise_core.sv
dv/tb.sv
